FILE: rtl/core/cdstp_pkg.sv
// Package for the calendar date stepper: command and status codes, controller
// states, the control and status structs and the month length table.
// No dependencies.
`timescale 1ns / 1ps

package cdstp_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [YearW-1:0]  ResetYear  = 14'd2000;
  localparam logic [MonthW-1:0] MonthJan   = 4'd1;
  localparam logic [MonthW-1:0] MonthDec   = 4'd12;
  localparam logic [DayW-1:0]   DayFirst   = 5'd1;
  localparam logic [DayW-1:0]   DayLastDec = 5'd31;

  // (y * RecipHundred) >> RecipShift equals y / 100 for every 14-bit year
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int unsigned RecipShift   = 19;
  localparam int unsigned QuotW        = 8;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_BACK = 2'd2,
    CMD_NOP  = 2'd3
  } cdstp_cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_LIMIT  = 2'd2
  } cdstp_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_MUL,
    S_LOAD_CHK,
    S_STEP,
    S_LEAP_MUL,
    S_LEAP_CMP,
    S_DONE
  } cdstp_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;        // latch the input word
    logic leap_mul;       // register year / 100
    logic leap_sel_load;  // leap unit works on the loaded year
    logic leap_upd;       // write the leap flag of the current year
    logic load_check;     // validate and commit a load
    logic step;           // move one day
    logic set_limit;      // flag the year limit in the status
    logic out_load;       // move the result into the output register
  } cdstp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic       cnt_zero;
    logic       blocked;
    logic       wrap;
    logic       out_free;
  } cdstp_sts_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = '0;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:      len = 5'd31;
      default:                 len = '0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/cdstp_ctrl.sv
// Controller of the calendar date stepper: sequences load checks, day steps
// and leap recomputation. Depends on cdstp_pkg.
`timescale 1ns / 1ps

module cdstp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  cdstp_pkg::cdstp_cmd_e       in_cmd_i,
  output logic                        in_ready_o,
  input  cdstp_pkg::cdstp_sts_t       sts_i,
  output cdstp_pkg::cdstp_ctl_t       ctl_o
);
  import cdstp_pkg::*;

  cdstp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          unique case (in_cmd_i)
            CMD_LOAD:           state_d = S_LOAD_MUL;
            CMD_FWD, CMD_BACK:  state_d = S_STEP;
            CMD_NOP:            state_d = S_DONE;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_LOAD_MUL: begin
        ctl_o.leap_mul      = 1'b1;
        ctl_o.leap_sel_load = 1'b1;
        state_d             = S_LOAD_CHK;
      end
      S_LOAD_CHK: begin
        ctl_o.leap_sel_load = 1'b1;
        ctl_o.load_check    = 1'b1;
        state_d             = S_DONE;
      end
      S_STEP: begin
        priority if (sts_i.cnt_zero) begin
          state_d = S_DONE;
        end else if (sts_i.blocked) begin
          // drop the remaining days
          ctl_o.set_limit = 1'b1;
          state_d         = S_DONE;
        end else begin
          ctl_o.step = 1'b1;
          // a new year needs its leap flag before the next step
          state_d    = sts_i.wrap ? S_LEAP_MUL : S_STEP;
        end
      end
      S_LEAP_MUL: begin
        ctl_o.leap_mul = 1'b1;
        state_d        = S_LEAP_CMP;
      end
      S_LEAP_CMP: begin
        ctl_o.leap_upd = 1'b1;
        state_d        = S_STEP;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/cdstp_dp.sv
// Datapath of the calendar date stepper: date registers, day stepping,
// leap year unit, load check and output register. Depends on cdstp_pkg.
`timescale 1ns / 1ps

module cdstp_dp #(
  parameter int unsigned COUNT_BITS = 12,
  parameter int unsigned YEAR_MAX   = 9999
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [39:0]                 in_data_i,
  input  cdstp_pkg::cdstp_cmd_e       in_cmd_i,
  output logic [23:0]                 out_data_o,
  output logic [1:0]                  out_user_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  cdstp_pkg::cdstp_ctl_t       ctl_i,
  output cdstp_pkg::cdstp_sts_t       sts_o
);
  import cdstp_pkg::*;

  localparam logic [YearW-1:0] YearMax = YearW'(YEAR_MAX);

  // latched input word
  cdstp_cmd_e             cmd_q;
  logic [YearW-1:0]       ly_q;
  logic [MonthW-1:0]      lm_q;
  logic [DayW-1:0]        ld_q;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic [15:0]            cnt_ext;

  // current date
  logic [YearW-1:0]       year_q;
  logic [MonthW-1:0]      month_q;
  logic [DayW-1:0]        day_q;
  logic                   leap_q;

  cdstp_status_e          status_q;

  // leap unit
  logic [YearW-1:0]       year_src;
  logic [26:0]            mul_full;
  logic [QuotW-1:0]       quot_q;
  logic [14:0]            hund;
  logic                   century;
  logic                   leap_calc;

  // stepping
  logic                   back;
  logic [DayW-1:0]        cur_len;
  logic [DayW-1:0]        prev_len;
  logic                   year_end;
  logic                   year_start;
  logic                   load_ok;

  // output register
  logic [YearW-1:0]       oyear_q;
  logic [MonthW-1:0]      omonth_q;
  logic [DayW-1:0]        oday_q;
  logic                   oleap_q;
  cdstp_status_e          ostatus_q;
  logic                   ovalid_q;

  assign cnt_ext  = {4'b0, in_data_i[34:23]};

  assign year_src = ctl_i.leap_sel_load ? ly_q : year_q;
  assign mul_full = 27'(year_src) * 27'(RecipHundred);
  // quot * 100 as shifts and adds
  assign hund     = {1'b0, quot_q, 6'b0} + {2'b0, quot_q, 5'b0} + {5'b0, quot_q, 2'b0};
  assign century  = (hund == {1'b0, year_src});
  assign leap_calc = (year_src[1:0] == 2'b00) && (!century || (quot_q[1:0] == 2'b00));

  assign back       = (cmd_q == CMD_BACK);
  assign cur_len    = month_len(month_q, leap_q);
  assign prev_len   = month_len(month_q - 4'd1, leap_q);
  assign year_end   = (month_q == MonthDec) && (day_q == DayLastDec);
  assign year_start = (month_q == MonthJan) && (day_q == DayFirst);

  assign load_ok = (ly_q <= YearMax) && (lm_q >= MonthJan) && (lm_q <= MonthDec) &&
                   (ld_q != '0) && (ld_q <= month_len(lm_q, leap_calc));

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.blocked  = back ? (year_start && (year_q == '0))
                               : (year_end && (year_q >= YearMax));
  assign sts_o.wrap     = back ? year_start : year_end;
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= in_cmd_i;
      ly_q  <= in_data_i[13:0];
      lm_q  <= in_data_i[17:14];
      ld_q  <= in_data_i[22:18];
      cnt_q <= cnt_ext[COUNT_BITS-1:0];
    end else if (ctl_i.step) begin
      cnt_q <= cnt_q - COUNT_BITS'(1);
    end
    if (ctl_i.leap_mul) begin
      quot_q <= mul_full[RecipShift +: QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.capture) begin
      status_q <= ST_OK;
    end else if (ctl_i.set_limit) begin
      status_q <= ST_LIMIT;
    end else if (ctl_i.load_check && !load_ok) begin
      status_q <= ST_REJECT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= ResetYear;
      month_q <= MonthJan;
      day_q   <= DayFirst;
      leap_q  <= 1'b1;
    end else begin
      priority if (ctl_i.load_check) begin
        if (load_ok) begin
          year_q  <= ly_q;
          month_q <= lm_q;
          day_q   <= ld_q;
          leap_q  <= leap_calc;
        end
      end else if (ctl_i.leap_upd) begin
        leap_q <= leap_calc;
      end else if (ctl_i.step) begin
        if (back) begin
          priority if (year_start) begin
            year_q  <= year_q - 14'd1;
            month_q <= MonthDec;
            day_q   <= DayLastDec;
          end else if (day_q <= DayFirst) begin
            month_q <= month_q - 4'd1;
            day_q   <= prev_len;
          end else begin
            day_q <= day_q - 5'd1;
          end
        end else begin
          priority if (year_end) begin
            year_q  <= year_q + 14'd1;
            month_q <= MonthJan;
            day_q   <= DayFirst;
          end else if (day_q >= cur_len) begin
            month_q <= month_q + 4'd1;
            day_q   <= DayFirst;
          end else begin
            day_q <= day_q + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      oyear_q   <= year_q;
      omonth_q  <= month_q;
      oday_q    <= day_q;
      oleap_q   <= leap_q;
      ostatus_q <= status_q;
    end
  end

  assign out_data_o  = {oleap_q, oday_q, omonth_q, oyear_q};
  assign out_user_o  = ostatus_q;
  assign out_valid_o = ovalid_q;

endmodule

FILE: rtl/core/calendar_date_stepper.sv
// Calendar date stepper top level: joins the controller and the datapath.
// Depends on cdstp_pkg, cdstp_ctrl and cdstp_dp.
//
// Usage: one command word enters on the s_axis channel; tuser carries the
// command (load, advance, go back, no operation) and tdata the load date and
// day count. Exactly one result word leaves on the m_axis channel with the
// date and leap flag in tdata and the status (ok, load rejected, year limit)
// in tuser.
// Sequence from acceptance to result valid: a load passes S_LOAD_MUL,
// S_LOAD_CHK and S_DONE, a no operation goes straight to S_DONE, and a step
// command stays in S_STEP while it moves its days, leaving it at each year
// boundary crossed so that the divide-by-100 unit recomputes the leap flag
// of the new year in S_LEAP_MUL and S_LEAP_CMP. The stepping loop sets the
// rate: one day per cycle, save for the stall at each year crossed.
// A new command word is taken only when the previous one has been finished;
// the output register lets it be taken while the last result still waits.
// Reset sets the date to 2000-01-01 and empties the output register.
// When the receiver stalls, the result holds in the output register and the
// next finished result waits in the datapath, the controller in S_DONE, until the register frees.
`timescale 1ns / 1ps

module calendar_date_stepper #(
  parameter int unsigned COUNT_BITS = 12,
  parameter int unsigned YEAR_MAX   = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // load_year[13:0], load_month[17:14], load_day[22:18], step_count[34:23]
  input  logic [39:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_year[13:0], out_month[17:14], out_day[22:18], is_leap[23]
  output logic [23:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o
);
  import cdstp_pkg::*;

  cdstp_ctl_t ctl;
  cdstp_sts_t sts;
  cdstp_cmd_e in_cmd;

  assign in_cmd = cdstp_cmd_e'(s_axis_tuser_i);

  cdstp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (in_cmd),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  cdstp_dp #(
    .COUNT_BITS (COUNT_BITS),
    .YEAR_MAX   (YEAR_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_cmd_i    (in_cmd),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule
